// ===== sv/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared constants for the positional array list: capacity, derived widths
// and command codes.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY = 16;
  // slot address width and element count width (count holds CAPACITY itself)
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

endpackage

// ===== sv/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed 32-bit words held in one synchronous slot memory,
// with insert/delete at front, rear or index and a dump command.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+----------------
//  in      | in_cmd, in_item, in_position            | in  | in_valid/in_stall
//  out     | out_ok, out_length, out_elem,           | out | out_valid/out_stall
//          | out_elem_valid, out_last                |     |
//
// Operation: an insert or delete moves each shifted element
//   through the slot memory's single read port (each word is read, then
//   written back in the following cycle).
//   A dump reads each element, then loads it into the output register.
// Reset: rst_n (sync, active low) clears the count and control; slot
//   contents are not cleared, only entries below the count are ever read.
// Stalls: out_stall holds the output register; the sequencer waits for it.
//   in_stall is high whenever a command is in progress.
// ----------------------------------------------------------------------------
module positional_array_list (
  input  logic                               clk,
  input  logic                               rst_n,
  // command item
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pal_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [pal_pkg::DATA_W-1:0]  in_item,
  input  logic [pal_pkg::POS_W-1:0]          in_position,
  // result item
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_ok,
  output logic [pal_pkg::POS_W-1:0]          out_length,
  output logic signed [pal_pkg::DATA_W-1:0]  out_elem,
  output logic                               out_elem_valid,
  output logic                               out_last
);

  localparam int AW = pal_pkg::AW;
  localparam int CW = pal_pkg::CW;
  localparam int DW = pal_pkg::DATA_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SHIFT   = 3'd1;
  localparam logic [2:0] ST_RESP    = 3'd2;
  localparam logic [2:0] ST_DUMP_RD = 3'd3;
  localparam logic [2:0] ST_DUMP_WT = 3'd4;

  // --------------------------------------------------------------------------
  // slot memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  logic [DW-1:0] mem [pal_pkg::CAPACITY];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // control and payload registers
  // --------------------------------------------------------------------------
  logic [2:0]    state_r,    state_nxt;
  logic [CW-1:0] fill_r,     fill_nxt;
  logic          is_ins_r,   is_ins_nxt;   // current op is an insert
  logic          ok_r,       ok_nxt;
  logic [AW-1:0] pos_r,      pos_nxt;      // target slot
  logic [DW-1:0] item_r,     item_nxt;
  logic [AW-1:0] src_r,      src_nxt;      // next slot to read while shifting
  logic [CW-1:0] mv_cnt_r,   mv_cnt_nxt;   // reads left in the shift
  logic          pend_r,     pend_nxt;     // read data waiting to be written
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [CW-1:0] idx_r,      idx_nxt;      // dump index

  logic                 out_valid_r,      out_valid_nxt;
  logic                 out_ok_r,         out_ok_nxt;
  logic [CW-1:0]        out_len_r,        out_len_nxt;
  logic [DW-1:0]        out_elem_r,       out_elem_nxt;
  logic                 out_elem_valid_r, out_elem_valid_nxt;
  logic                 out_last_r,       out_last_nxt;

  logic          out_free;
  logic          in_take;

  // command decode on the incoming item
  logic [pal_pkg::POS_W-1:0] fill_ext;
  logic [pal_pkg::POS_W-1:0] tgt_pos;
  logic                      cmd_ins;
  logic                      cmd_del;
  logic                      cmd_ok;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign fill_ext = pal_pkg::POS_W'(fill_r);

  always_comb begin
    cmd_ins = 1'b0;
    cmd_del = 1'b0;
    tgt_pos = '0;
    case (in_cmd)
      pal_pkg::CMD_INS_FRONT: begin cmd_ins = 1'b1; tgt_pos = '0;          end
      pal_pkg::CMD_INS_REAR:  begin cmd_ins = 1'b1; tgt_pos = fill_ext;    end
      pal_pkg::CMD_INS_AT:    begin cmd_ins = 1'b1; tgt_pos = in_position; end
      pal_pkg::CMD_DEL_FRONT: begin cmd_del = 1'b1; tgt_pos = '0;          end
      pal_pkg::CMD_DEL_REAR:  begin
        cmd_del = 1'b1;
        tgt_pos = fill_ext - pal_pkg::POS_W'(1);
      end
      pal_pkg::CMD_DEL_AT:    begin cmd_del = 1'b1; tgt_pos = in_position; end
      default: begin
        cmd_ins = 1'b0;
        cmd_del = 1'b0;
      end
    endcase
    // full list / index beyond count on insert; empty / out of range on delete
    cmd_ok = (cmd_ins && (fill_r < CW'(pal_pkg::CAPACITY)) && (tgt_pos <= fill_ext)) ||
             (cmd_del && (fill_r != '0) && (tgt_pos < fill_ext));
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt          = state_r;
    fill_nxt           = fill_r;
    is_ins_nxt         = is_ins_r;
    ok_nxt             = ok_r;
    pos_nxt            = pos_r;
    item_nxt           = item_r;
    src_nxt            = src_r;
    mv_cnt_nxt         = mv_cnt_r;
    pend_nxt           = pend_r;
    pend_addr_nxt      = pend_addr_r;
    idx_nxt            = idx_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_ok_nxt         = out_ok_r;
    out_len_nxt        = out_len_r;
    out_elem_nxt       = out_elem_r;
    out_elem_valid_nxt = out_elem_valid_r;
    out_last_nxt       = out_last_r;
    wr_en              = 1'b0;
    wr_addr            = pend_addr_r;
    wr_data            = rd_data_r;
    rd_en              = 1'b0;
    rd_addr            = src_r;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          is_ins_nxt = cmd_ins;
          ok_nxt     = cmd_ok;
          pos_nxt    = AW'(tgt_pos);
          item_nxt   = in_item;
          pend_nxt   = 1'b0;
          idx_nxt    = '0;
          if (in_cmd == pal_pkg::CMD_DUMP) begin
            ok_nxt    = 1'b1;
            state_nxt = (fill_r == '0) ? ST_RESP : ST_DUMP_RD;
          end else if (cmd_ok) begin
            state_nxt = ST_SHIFT;
            if (cmd_ins) begin
              // move slots fill-1 .. pos one place up, top first
              mv_cnt_nxt = fill_r - CW'(tgt_pos);
              src_nxt    = AW'(fill_r - CW'(1));
            end else begin
              // move slots pos+1 .. fill-1 one place down, bottom first
              mv_cnt_nxt = fill_r - CW'(tgt_pos) - CW'(1);
              src_nxt    = AW'(tgt_pos + pal_pkg::POS_W'(1));
            end
          end else begin
            state_nxt = ST_RESP;
          end
        end
      end

      ST_SHIFT: begin
        // write back the word read last cycle
        if (pend_r) begin
          wr_en    = 1'b1;
          pend_nxt = 1'b0;
        end
        if (mv_cnt_r != '0) begin
          rd_en         = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = is_ins_r ? (src_r + AW'(1)) : (src_r - AW'(1));
          src_nxt       = is_ins_r ? (src_r - AW'(1)) : (src_r + AW'(1));
          mv_cnt_nxt    = mv_cnt_r - CW'(1);
        end else if (!pend_r) begin
          if (is_ins_r) begin
            wr_en    = 1'b1;
            wr_addr  = pos_r;
            wr_data  = item_r;
            fill_nxt = fill_r + CW'(1);
          end else begin
            fill_nxt = fill_r - CW'(1);
          end
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        // single result: plain commands, rejects, dump of an empty list
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_ok_nxt         = ok_r;
          out_len_nxt        = fill_r;
          out_elem_nxt       = '0;
          out_elem_valid_nxt = 1'b0;
          out_last_nxt       = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end

      ST_DUMP_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_r[AW-1:0];
        state_nxt = ST_DUMP_WT;
      end

      ST_DUMP_WT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_ok_nxt         = 1'b1;
          out_len_nxt        = fill_r;
          out_elem_nxt       = rd_data_r;
          out_elem_valid_nxt = 1'b1;
          out_last_nxt       = (idx_r + CW'(1) == fill_r);
          idx_nxt            = idx_r + CW'(1);
          state_nxt          = (idx_r + CW'(1) == fill_r) ? ST_IDLE : ST_DUMP_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      mv_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      mv_cnt_r    <= mv_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_ins_r         <= is_ins_nxt;
    ok_r             <= ok_nxt;
    pos_r            <= pos_nxt;
    item_r           <= item_nxt;
    src_r            <= src_nxt;
    pend_addr_r      <= pend_addr_nxt;
    idx_r            <= idx_nxt;
    out_ok_r         <= out_ok_nxt;
    out_len_r        <= out_len_nxt;
    out_elem_r       <= out_elem_nxt;
    out_elem_valid_r <= out_elem_valid_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_length     = pal_pkg::POS_W'(out_len_r);
  assign out_elem       = out_elem_r;
  assign out_elem_valid = out_elem_valid_r;
  assign out_last       = out_last_r;

endmodule
